@@ sv/lfa_pkg.sv @@
// ---------------------------------------------------------------------------
// lfa_pkg
// Shared types and constants for the LIFO free-list block pool allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package lfa_pkg;

  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 16;
  localparam int CAP_W      = 9;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int RSIZE_W    = SIZE_W + 1;

  localparam int MAX_OBJECTS_DEFAULT = 256;

  localparam logic [RSIZE_W-1:0] SIZE_ROUND = RSIZE_W'(7);

  localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_REBUILD = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_BASE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd2;

  localparam logic [ADDR_W-1:0] BASE_RESET     = '0;
  localparam logic [SIZE_W-1:0] SIZE_RESET     = 16'd8;
  localparam logic [CAP_W-1:0]  CAPACITY_RESET = 9'd256;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] release_address;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   item_address;
    logic [CAP_W-1:0]    free_slots;
    logic                is_empty;
    logic                is_full;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic rb_start;
    logic rb_step;
    logic rb_finish;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic is_rebuild;
    logic rb_done;
  } sts_t;

endpackage

`default_nettype wire

@@ sv/lfa_channels.sv @@
// ---------------------------------------------------------------------------
// lfa_channels
// Valid/ready channel interfaces for request and result words.
// ---------------------------------------------------------------------------
`default_nettype none

interface lfa_in_if;
  logic              valid;
  logic              ready;
  lfa_pkg::in_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface lfa_out_if;
  logic               valid;
  logic               ready;
  lfa_pkg::out_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

@@ sv/lfa_ram.sv @@
// ---------------------------------------------------------------------------
// lfa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module lfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/lfa_ctrl.sv @@
// ---------------------------------------------------------------------------
// lfa_ctrl
// Sequencer: accepts a request, then runs the exec state or the rebuild sweep.
// ---------------------------------------------------------------------------
`default_nettype none

module lfa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire lfa_pkg::sts_t sts,
  output lfa_pkg::cmd_t      cmd
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_EXEC    = 2'd1;
  localparam logic [1:0] S_REBUILD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !sts.out_busy;
        if (in_valid && !sts.out_busy) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_rebuild) begin
          cmd.rb_start = 1'b1;
          state_next   = S_REBUILD;
        end else begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REBUILD: begin
        if (sts.rb_done) begin
          cmd.rb_finish = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.rb_step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/lfa_dpath.sv @@
// ---------------------------------------------------------------------------
// lfa_dpath
// Config registers, stack pointer, free stack RAM, region check, result word.
// ---------------------------------------------------------------------------
`default_nettype none

module lfa_dpath #(
  parameter int MAX_OBJECTS = lfa_pkg::MAX_OBJECTS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wen,
  input  wire logic [lfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lfa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire lfa_pkg::in_word_t                  in_word,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output lfa_pkg::out_word_t                       out_word,
  input  wire lfa_pkg::cmd_t                       cmd,
  output lfa_pkg::sts_t                            sts
);

  localparam int ADDR_W  = lfa_pkg::ADDR_W;
  localparam int RSIZE_W = lfa_pkg::RSIZE_W;
  localparam int CAP_W   = lfa_pkg::CAP_W;
  localparam int TOP_W   = $clog2(MAX_OBJECTS + 1);
  localparam int IDX_W   = $clog2(MAX_OBJECTS);
  localparam int CMP_W   = (TOP_W > CAP_W) ? TOP_W : CAP_W;
  localparam int PROD_W  = TOP_W + RSIZE_W;
  localparam int END_W   = ((PROD_W > ADDR_W) ? PROD_W : ADDR_W) + 1;

  logic [ADDR_W-1:0]          base;
  logic [lfa_pkg::SIZE_W-1:0] size_raw;
  logic [CAP_W-1:0]           capacity;

  logic [lfa_pkg::OP_W-1:0] op;
  logic [ADDR_W-1:0]        rel_addr;

  logic [TOP_W-1:0]  top;
  logic [TOP_W-1:0]  top_next;
  logic [TOP_W-1:0]  rb_idx;
  logic [ADDR_W-1:0] rb_acc;
  logic [PROD_W-1:0] prod;

  logic [RSIZE_W-1:0] size_r;
  logic [CMP_W-1:0]   cap_ext;
  logic [TOP_W-1:0]   cap_eff;
  logic [END_W-1:0]   region_end;
  logic               in_region;
  logic               rel_full;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [ADDR_W-1:0]        ram_wdata;
  logic [ADDR_W-1:0]        ram_rdata;
  logic [lfa_pkg::STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]        res_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= lfa_pkg::BASE_RESET;
      size_raw  <= lfa_pkg::SIZE_RESET;
      capacity  <= lfa_pkg::CAPACITY_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        lfa_pkg::REG_BASE:     base      <= cfg_wdata[ADDR_W-1:0];
        lfa_pkg::REG_SIZE:     size_raw  <= cfg_wdata[lfa_pkg::SIZE_W-1:0];
        lfa_pkg::REG_CAPACITY: capacity  <= cfg_wdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign size_r  = (RSIZE_W'(size_raw) + lfa_pkg::SIZE_ROUND) & ~lfa_pkg::SIZE_ROUND;
  assign cap_ext = CMP_W'(capacity);
  assign cap_eff = (cap_ext > CMP_W'(MAX_OBJECTS)) ? TOP_W'(MAX_OBJECTS) : TOP_W'(cap_ext);

  // region length, registered ahead of the compare
  always_ff @(posedge clk) begin
    prod <= PROD_W'(cap_eff) * PROD_W'(size_r);
  end

  assign region_end = END_W'(base) + END_W'(prod);
  assign in_region  = (rel_addr >= base) && (END_W'(rel_addr) < region_end);
  assign rel_full   = (top >= cap_eff) || (top >= TOP_W'(MAX_OBJECTS));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= in_word.operation;
      rel_addr <= in_word.release_address;
    end
  end

  always_comb begin
    top_next   = top;
    res_status = lfa_pkg::ST_OK;
    res_addr   = '0;
    ram_we     = 1'b0;
    ram_waddr  = IDX_W'(top);
    ram_wdata  = rel_addr;
    if (cmd.exec) begin
      case (op)
        lfa_pkg::OP_ACQUIRE: begin
          if (top == '0) begin
            res_status = lfa_pkg::ST_EMPTY;
          end else begin
            top_next = top - 1'b1;
            res_addr = ram_rdata;
          end
        end
        lfa_pkg::OP_RELEASE: begin
          if (rel_full) begin
            res_status = lfa_pkg::ST_FULL;
          end else if (!in_region) begin
            res_status = lfa_pkg::ST_INVALID;
          end else begin
            ram_we   = 1'b1;
            top_next = top + 1'b1;
          end
        end
        default: ;
      endcase
    end else if (cmd.rb_step) begin
      ram_we    = 1'b1;
      ram_waddr = IDX_W'(rb_idx);
      ram_wdata = rb_acc;
    end else if (cmd.rb_finish) begin
      top_next = cap_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top <= '0;
    end else begin
      top <= top_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rb_start) begin
      rb_idx <= '0;
      rb_acc <= base;
    end else if (cmd.rb_step) begin
      rb_idx <= rb_idx + 1'b1;
      rb_acc <= rb_acc + ADDR_W'(size_r);
    end
  end

  // read port sits on the top entry so an acquire has its data at exec
  lfa_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (MAX_OBJECTS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (IDX_W'(top - 1'b1)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec || cmd.rb_finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec || cmd.rb_finish) begin
      out_word.status       <= res_status;
      out_word.item_address <= res_addr;
      out_word.free_slots   <= CAP_W'(top_next);
      out_word.is_empty     <= (top_next == '0);
      out_word.is_full      <= (top_next >= cap_eff);
    end
  end

  assign sts.out_busy   = out_valid && !out_ready;
  assign sts.is_rebuild = (op == lfa_pkg::OP_REBUILD);
  assign sts.rb_done    = (rb_idx == cap_eff);

endmodule

`default_nettype wire

@@ sv/lifo_free_list_allocator_core.sv @@
// ---------------------------------------------------------------------------
// lifo_free_list_allocator_core
// Fixed-size block pool with a LIFO stack of free object addresses.
// ---------------------------------------------------------------------------
//  channel  dir  word fields                                        handshake
//  in_ch    in   operation, release_address                          valid/ready
//  out_ch   out  status, item_address, free_slots, is_empty, is_full valid/ready
//  cfg      in   cfg_index, cfg_wdata                                cfg_wen
//
// Acquire, release and unknown ops: the word is registered at accept, the
// exec state registers the result (stack RAM read port is held on the top
// entry; release writes in the exec cycle). Rebuild writes one entry per cycle.
// A new word is taken once the result register is free or being drained.
// Reset empties the stack; entries are undefined until written, no sweep.
// ---------------------------------------------------------------------------
`default_nettype none

module lifo_free_list_allocator_core #(
  parameter int MAX_OBJECTS = lfa_pkg::MAX_OBJECTS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  lfa_in_if.sink                               in_ch,
  lfa_out_if.source                            out_ch,
  input  wire logic                            cfg_wen,
  input  wire logic [lfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lfa_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  lfa_pkg::cmd_t cmd;
  lfa_pkg::sts_t sts;
  logic          in_ready;

  assign in_ch.ready = in_ready;

  lfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfa_dpath #(
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_ch.word),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_word  (out_ch.word),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

@@ verif/lfa_tb_pkg.sv @@
// ---------------------------------------------------------------------------
// lfa_tb_pkg
// Scoreboard for the block pool allocator: keeps its own copy of the free
// address stack and the pool registers, predicts one result word per
// accepted request word and checks result words in order, field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

package lfa_tb_pkg;

  import lfa_pkg::*;

  class pool_scoreboard;

    logic [ADDR_W-1:0] free_addrs [MAX_OBJECTS_DEFAULT];
    int unsigned       stack_depth;
    logic [ADDR_W-1:0] pool_base;
    logic [SIZE_W-1:0] obj_size;
    logic [CAP_W-1:0]  pool_cap;
    out_word_t         expected_words [$];
    int                errors;

    function new();
      stack_depth = 0;
      pool_base   = BASE_RESET;
      obj_size    = SIZE_RESET;
      pool_cap    = CAPACITY_RESET;
      errors      = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BASE:     pool_base = data[ADDR_W-1:0];
        REG_SIZE:     obj_size  = data[SIZE_W-1:0];
        REG_CAPACITY: pool_cap  = data[CAP_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function out_word_t predict_pool_op(in_word_t req);
      int unsigned     eff_cap;
      longint unsigned rsize;
      longint unsigned region_end;
      out_word_t       res;
      eff_cap = (pool_cap > MAX_OBJECTS_DEFAULT) ? MAX_OBJECTS_DEFAULT : pool_cap;
      rsize   = (64'(obj_size) + 64'(SIZE_ROUND)) & ~64'(SIZE_ROUND);
      res     = '0;
      res.status = ST_OK;
      case (req.operation)
        OP_ACQUIRE: begin
          if (stack_depth == 0) begin
            res.status = ST_EMPTY;
          end else begin
            stack_depth--;
            res.item_address = free_addrs[stack_depth];
          end
        end
        OP_RELEASE: begin
          region_end = 64'(pool_base) + 64'(eff_cap) * rsize;
          if (stack_depth >= eff_cap || stack_depth >= MAX_OBJECTS_DEFAULT) begin
            res.status = ST_FULL;
          end else if (64'(req.release_address) < 64'(pool_base) ||
                       64'(req.release_address) >= region_end) begin
            res.status = ST_INVALID;
          end else begin
            free_addrs[stack_depth] = req.release_address;
            stack_depth++;
          end
        end
        OP_REBUILD: begin
          for (int unsigned i = 0; i < eff_cap; i++)
            free_addrs[i] = ADDR_W'(64'(pool_base) + 64'(i) * rsize);
          stack_depth = eff_cap;
        end
        default: ;
      endcase
      res.free_slots = CAP_W'(stack_depth);
      res.is_empty   = (stack_depth == 0);
      res.is_full    = (stack_depth >= eff_cap);
      return res;
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      if (errors < 40)
        $display("tb: %s mismatch: got %0h, want %0h", what, got, want);
      errors++;
    endtask

    task note_request(in_word_t req);
      expected_words.push_back(predict_pool_op(req));
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        report("unexpected word", 64'(got), 0);
      end else begin
        want = expected_words.pop_front();
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.item_address !== want.item_address)
          report("item_address", got.item_address, want.item_address);
        if (got.free_slots !== want.free_slots)
          report("free_slots", got.free_slots, want.free_slots);
        if (got.is_empty !== want.is_empty) report("is_empty", got.is_empty, want.is_empty);
        if (got.is_full !== want.is_full) report("is_full", got.is_full, want.is_full);
      end
    endtask

    task finish();
      if (expected_words.size() != 0)
        report("missing words", expected_words.size(), 0);
    endtask

  endclass

endpackage

@@ verif/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Block pool allocator test: directed acquire/release/rebuild words over the
// region edges, then random phases with new pool settings, random idling on
// both channels, a long result stall and full drains between phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  import lfa_pkg::*;
  import lfa_tb_pkg::*;

  localparam int RANDOM_WORDS = 1300;
  localparam int HOLD_CYCLES  = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_wen   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  lfa_in_if  in_ch ();
  lfa_out_if out_ch ();

  pool_scoreboard sb = new();

  int   idle_pct   = 16;
  bit   hold_req   = 1'b0;
  int   sent_words = 0;

  logic [ADDR_W-1:0] cur_base = BASE_RESET;
  logic [SIZE_W-1:0] cur_size = SIZE_RESET;
  logic [CAP_W-1:0]  cur_cap  = CAPACITY_RESET;

  lifo_free_list_allocator_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) sb.note_request(in_ch.word);
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.word);
  end

  // result side
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready = ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic send(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.word  = '{operation: op, release_address: addr};
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent_words++;
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wen   = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    sb.set_register(idx, data);
    @(negedge clk);
  endtask

  task automatic configure(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] size,
                           logic [CAP_W-1:0] cap);
    write_reg(REG_BASE, CFG_DATA_W'(base));
    write_reg(REG_SIZE, CFG_DATA_W'(size));
    write_reg(REG_CAPACITY, CFG_DATA_W'(cap));
    cfg_wen  = 1'b0;
    cur_base = base;
    cur_size = size;
    cur_cap  = cap;
  endtask

  task automatic random_phase(int n);
    int                r;
    longint unsigned   rsize;
    longint unsigned   span;
    logic [ADDR_W-1:0] a;
    rsize = (64'(cur_size) + 64'(SIZE_ROUND)) & ~64'(SIZE_ROUND);
    span  = 64'(cur_cap) * rsize;
    if ($urandom_range(9) < 7) send(OP_REBUILD, $urandom);
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 3) begin
        send(OP_REBUILD, $urandom);
      end else if (r < 48) begin
        send(OP_ACQUIRE, $urandom);
      end else begin
        r = $urandom_range(99);
        if (r < 55)      a = cur_base + 32'($urandom_range(cur_cap - 1)) * 32'(rsize);
        else if (r < 75) a = ADDR_W'(64'(cur_base) + ({$urandom, $urandom} % span));
        else if (r < 83) a = cur_base - 32'($urandom_range(16, 1));
        else if (r < 91) a = ADDR_W'(64'(cur_base) + span - 64'($urandom_range(1)));
        else             a = $urandom;
        send(OP_RELEASE, a);
      end
    end
    drain();
  endtask

  initial begin
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
    logic [CAP_W-1:0]  cap;
    int                phase;
    in_ch.valid = 1'b0;
    in_ch.word  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: base 0, 8-byte objects, 256 of them, stack empty
    send(OP_ACQUIRE, '0);
    send(OP_RELEASE, 32'h0000_0000);
    send(OP_RELEASE, 32'h0000_07FF);
    send(OP_RELEASE, 32'h0000_0800);
    send(OP_RELEASE, 32'hFFFF_FFFF);
    send(OP_ACQUIRE, 32'hFFFF_FFFF);
    send(OP_ACQUIRE, '0);
    send(OP_ACQUIRE, '0);
    send(OP_REBUILD, '0);
    send(OP_RELEASE, 32'h0000_0008);
    send(OP_ACQUIRE, '0);
    drain();

    // single object: full check wins over region check
    configure(32'hFFFF_F000, 16'd1, 9'd1);
    send(OP_REBUILD, '0);
    send(OP_RELEASE, 32'h0000_0000);
    send(OP_ACQUIRE, '0);
    send(OP_RELEASE, 32'hFFFF_EFFF);
    send(OP_RELEASE, 32'hFFFF_F007);
    send(OP_ACQUIRE, '0);
    drain();

    // largest objects: region end past 4G, rebuilt addresses wrap
    configure(32'hFFFF_FF00, 16'hFFFF, 9'd256);
    send(OP_REBUILD, '0);
    send(OP_ACQUIRE, '0);
    send(OP_RELEASE, 32'hFFFF_FFFF);
    drain();

    // capacity lowered below the stack depth without a rebuild
    configure(32'hFFFF_FF00, 16'hFFFF, 9'd3);
    send(OP_RELEASE, 32'hFFFF_FF00);
    send(OP_ACQUIRE, '0);
    drain();

    phase = 0;
    while (sent_words < RANDOM_WORDS + 22) begin
      case ($urandom_range(4))
        0:       base = '0;
        1:       base = 32'hFFFF_FFFF;
        2:       base = $urandom & ~32'h7;
        default: base = $urandom;
      endcase
      case ($urandom_range(4))
        0:       size = 16'd1;
        1:       size = 16'hFFFF;
        2:       size = 16'd8;
        3:       size = 16'($urandom_range(64, 1));
        default: size = 16'($urandom_range(65535, 1));
      endcase
      case ($urandom_range(5))
        0:       cap = 9'd1;
        1:       cap = 9'd256;
        2:       cap = 9'($urandom_range(8, 2));
        3:       cap = 9'($urandom_range(32, 1));
        default: cap = 9'($urandom_range(256, 1));
      endcase
      configure(base, size, cap);
      if (phase == 2) hold_req = 1'b1;
      idle_pct = (phase == 4) ? 0 : 16;
      random_phase($urandom_range(90, 40));
      phase++;
    end
    idle_pct = 16;

    repeat (260) @(negedge clk);
    sb.finish();
    if (sb.errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

@@ sim.f @@
sv/lfa_pkg.sv
sv/lfa_channels.sv
sv/lfa_ram.sv
sv/lfa_ctrl.sv
sv/lfa_dpath.sv
sv/lifo_free_list_allocator_core.sv
verif/lfa_tb_pkg.sv
verif/tb.sv
